// ===== rtl/mtl_pkg.sv =====
// Shared types, character codes and helpers for the markup token lexer.
// Used by every module of the block; depends on nothing.
package mtl_pkg;

  localparam int unsigned OffsetWidth = 24;
  localparam int unsigned LineWidth   = 20;
  localparam int unsigned MaxTokens   = 4;
  localparam int unsigned SlotW       = $clog2(MaxTokens);
  localparam int unsigned TokCntW     = $clog2(MaxTokens + 1);
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [3:0] {
    KindText     = 4'd0,
    KindDoubleAt = 4'd1,
    KindAt       = 4'd2,
    KindIdent    = 4'd3,
    KindHash     = 4'd4,
    KindDash     = 4'd5,
    KindBold     = 4'd6,
    KindItalic   = 4'd7,
    KindNewline  = 4'd8
  } mtl_kind_e;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeSkip   = 2'd1,
    ModeWord   = 2'd2
  } mtl_mode_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } mtl_in_t;

  typedef struct packed {
    mtl_kind_e              token_kind;
    logic [LineWidth-1:0]   start_line;
    logic [OffsetWidth-1:0] start_column;
    logic [OffsetWidth-1:0] start_offset;
    logic [OffsetWidth-1:0] text_begin;
    logic [OffsetWidth-1:0] text_len;
    logic                   run_end;
  } mtl_token_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic [TokCntW-1:0]           count;
    mtl_token_t [MaxTokens-1:0]   tok;
  } mtl_bundle_t;

  typedef struct packed {
    logic [LineWidth-1:0]   line;
    logic [OffsetWidth-1:0] column;
    logic [OffsetWidth-1:0] offset;
  } mtl_pos_t;

  typedef struct packed {
    mtl_pos_t               at;
    logic [OffsetWidth-1:0] length;
  } mtl_run_t;

  function automatic logic [OffsetWidth-1:0] sat_off(logic [OffsetWidth-1:0] v);
    return (v == '1) ? v : v + OffsetWidth'(1);
  endfunction

  function automatic logic [LineWidth-1:0] sat_line(logic [LineWidth-1:0] v);
    return (v == '1) ? v : v + LineWidth'(1);
  endfunction

  function automatic mtl_pos_t pos_advance(mtl_pos_t p, logic [7:0] ch);
    mtl_pos_t r;
    r = p;
    if (ch == ChNl) begin
      r.line   = sat_line(p.line);
      r.column = OffsetWidth'(1);
    end else begin
      r.column = sat_off(p.column);
    end
    r.offset = sat_off(p.offset);
    return r;
  endfunction

  function automatic mtl_token_t mk_tok(mtl_kind_e k, mtl_pos_t p,
                                        logic [OffsetWidth-1:0] beg,
                                        logic [OffsetWidth-1:0] len);
    mtl_token_t t;
    t.token_kind   = k;
    t.start_line   = p.line;
    t.start_column = p.column;
    t.start_offset = p.offset;
    t.text_begin   = beg;
    t.text_len     = len;
    t.run_end      = 1'b0;
    return t;
  endfunction

  function automatic mtl_bundle_t push_tok(mtl_bundle_t bd, mtl_token_t t);
    mtl_bundle_t r;
    r = bd;
    if (bd.count < TokCntW'(MaxTokens)) begin
      r.tok[bd.count[SlotW-1:0]] = t;
      r.count = bd.count + TokCntW'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/mtl_front.sv =====
// Front end: takes one byte a beat while the queue is not full, runs the
// scanner state and builds the bundle of tokens that byte causes. Depends on mtl_pkg.
module mtl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mtl_pkg::mtl_in_t    in_data_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output mtl_pkg::mtl_bundle_t q_bundle_o
);
  import mtl_pkg::*;

  localparam mtl_pos_t PosReset = '{line: LineWidth'(1), column: OffsetWidth'(1),
                                    offset: '0};

  logic [7:0]             held_byte_q, held_byte_d;
  logic                   held_valid_q, held_valid_d;
  mtl_mode_e              mode_q, mode_d;
  mtl_pos_t               pos_q, pos_d;
  mtl_run_t               run_q, run_d;
  mtl_pos_t               marker_q, marker_d;
  logic [OffsetWidth-1:0] word_start_q, word_start_d;
  logic [OffsetWidth-1:0] word_len_q, word_len_d;
  mtl_bundle_t            bd;
  logic                   accept;
  logic                   used;
  logic                   do_norm;
  logic [7:0]             b;
  logic                   fin;

  function automatic mtl_bundle_t flush_run(mtl_bundle_t bdl, mtl_run_t r);
    mtl_bundle_t o;
    o = bdl;
    if (r.length != '0) begin
      o = push_tok(bdl, mk_tok(KindText, r.at, r.at.offset, r.length));
    end
    return o;
  endfunction

  function automatic mtl_run_t run_add(mtl_run_t r, mtl_pos_t p);
    mtl_run_t o;
    o = r;
    if (r.length == '0) begin
      o.at     = p;
      o.length = OffsetWidth'(1);
    end else begin
      o.length = sat_off(r.length);
    end
    return o;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNl);
  endfunction

  always_comb begin
    b            = in_data_i.byte_in;
    fin          = in_data_i.final_byte;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    mode_d       = mode_q;
    pos_d        = pos_q;
    run_d        = run_q;
    marker_d     = marker_q;
    word_start_d = word_start_q;
    word_len_d   = word_len_q;
    bd           = '0;
    used         = 1'b0;
    do_norm      = 1'b0;

    // resolve the held byte against this one
    if (held_valid_q) begin
      held_valid_d = 1'b0;
      if (held_byte_q == ChAt && b == ChAt) begin
        bd = flush_run(bd, run_d);
        run_d.length = '0;
        bd = push_tok(bd, mk_tok(KindDoubleAt, pos_d, '0, '0));
        pos_d = pos_advance(pos_advance(pos_d, ChAt), b);
        used = 1'b1;
      end else if (held_byte_q == ChAt) begin
        bd = flush_run(bd, run_d);
        run_d.length = '0;
        bd = push_tok(bd, mk_tok(KindAt, pos_d, '0, '0));
        marker_d = pos_d;
        pos_d = pos_advance(pos_d, ChAt);
        mode_d = ModeSkip;
      end else if ((held_byte_q == ChStar || held_byte_q == ChUnder) &&
                   b == held_byte_q) begin
        bd = flush_run(bd, run_d);
        run_d.length = '0;
        bd = push_tok(bd, mk_tok((held_byte_q == ChStar) ? KindBold : KindItalic,
                                 pos_d, '0, '0));
        pos_d = pos_advance(pos_advance(pos_d, held_byte_q), b);
        used = 1'b1;
      end else begin
        run_d  = run_add(run_d, pos_d);
        pos_d  = pos_advance(pos_d, held_byte_q);
        mode_d = ModeNormal;
      end
    end

    if (!used) begin
      case (mode_d)
        ModeSkip: begin
          if (!is_blank(b)) begin
            word_start_d = pos_d.offset;
            word_len_d   = OffsetWidth'(1);
            mode_d       = ModeWord;
          end
          pos_d = pos_advance(pos_d, b);
        end
        ModeWord: begin
          if (is_blank(b)) begin
            bd = push_tok(bd, mk_tok(KindIdent, marker_d, word_start_d, word_len_d));
            mode_d  = ModeNormal;
            do_norm = 1'b1;
          end else begin
            word_len_d = sat_off(word_len_d);
            pos_d      = pos_advance(pos_d, b);
          end
        end
        default: do_norm = 1'b1;
      endcase
    end

    if (do_norm) begin
      if (b == ChAt || b == ChStar || b == ChUnder) begin
        if (!fin) begin
          held_byte_d  = b;
          held_valid_d = 1'b1;
        end else if (b == ChAt) begin
          bd = flush_run(bd, run_d);
          run_d.length = '0;
          bd = push_tok(bd, mk_tok(KindAt, pos_d, '0, '0));
          marker_d = pos_d;
          pos_d = pos_advance(pos_d, ChAt);
          mode_d = ModeSkip;
        end else begin
          run_d = run_add(run_d, pos_d);
          pos_d = pos_advance(pos_d, b);
        end
      end else if (b == ChHash || b == ChDash || b == ChNl) begin
        bd = flush_run(bd, run_d);
        run_d.length = '0;
        bd = push_tok(bd, mk_tok((b == ChHash) ? KindHash :
                                 (b == ChDash) ? KindDash : KindNewline,
                                 pos_d, pos_d.offset, OffsetWidth'(1)));
        pos_d = pos_advance(pos_d, b);
      end else begin
        run_d = run_add(run_d, pos_d);
        pos_d = pos_advance(pos_d, b);
      end
    end

    // end of document: pending identifier out, text run dropped, state back to reset
    if (fin) begin
      if (mode_d == ModeSkip) begin
        bd = push_tok(bd, mk_tok(KindIdent, marker_d, pos_d.offset, '0));
      end else if (mode_d == ModeWord) begin
        bd = push_tok(bd, mk_tok(KindIdent, marker_d, word_start_d, word_len_d));
      end
      held_byte_d  = '0;
      held_valid_d = 1'b0;
      mode_d       = ModeNormal;
      pos_d        = PosReset;
      run_d        = '0;
      marker_d     = '0;
      word_start_d = '0;
      word_len_d   = '0;
    end

    if (bd.count != '0) begin
      bd.tok[SlotW'(bd.count - TokCntW'(1))].run_end = 1'b1;
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = accept && (bd.count != '0);
  assign q_bundle_o = bd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      mode_q       <= ModeNormal;
      pos_q        <= PosReset;
      run_q        <= '0;
      marker_q     <= '0;
      word_start_q <= '0;
      word_len_q   <= '0;
    end else if (accept) begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      mode_q       <= mode_d;
      pos_q        <= pos_d;
      run_q        <= run_d;
      marker_q     <= marker_d;
      word_start_q <= word_start_d;
      word_len_q   <= word_len_d;
    end
  end

  // only marker bytes are ever held, and only in normal mode
  a_held_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> ((held_byte_q == ChAt || held_byte_q == ChStar ||
                       held_byte_q == ChUnder) && mode_q == ModeNormal))
    else $error("held byte is not a marker or mode is not normal");

  a_fin_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.final_byte |=>
      !held_valid_q && mode_q == ModeNormal && pos_q == PosReset && run_q.length == '0)
    else $error("scanner state not back to reset after final byte");

endmodule

// ===== rtl/mtl_queue.sv =====
// Short bundle queue between the front end and the token serialiser.
// Depends on mtl_pkg for the bundle type.
module mtl_queue #(
  parameter int unsigned Depth = mtl_pkg::QueueDepthDefault  // 2 to 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mtl_pkg::mtl_bundle_t bundle_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output mtl_pkg::mtl_bundle_t head_o
);
  import mtl_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mtl_bundle_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// ===== rtl/mtl_back.sv =====
// Back end: walks the head bundle one token a beat into the output register
// unless the output stalls. Depends on mtl_pkg for the bundle and token types.
module mtl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  mtl_pkg::mtl_bundle_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output mtl_pkg::mtl_token_t  out_data_o,
  input  logic                 out_stall_i
);
  import mtl_pkg::*;

  logic [SlotW-1:0] slot_q;
  logic             out_valid_q;
  mtl_token_t       out_tok_q;
  logic             load;
  logic             last;

  assign load  = !empty_i && (!out_valid_q || !out_stall_i);
  assign last  = (TokCntW'(slot_q) + TokCntW'(1)) == head_i.count;
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        slot_q      <= last ? '0 : slot_q + SlotW'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_tok_q <= head_i.tok[slot_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_tok_q;

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (head_i.count != '0 && TokCntW'(slot_q) < head_i.count))
    else $error("slot index beyond head bundle");

  a_slot_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> slot_q == '0)
    else $error("slot index not rewound after bundle pop");

endmodule

// ===== rtl/markup_token_lexer_core.sv =====
// Top level of the markup token lexer: front end, bundle queue, serialiser.
// Depends on mtl_pkg, mtl_front, mtl_queue and mtl_back.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_stall_o    mtl_in_t    (byte_in, final_byte)
//   out      out  out_valid_o / out_stall_i  mtl_token_t (kind, location, text, run_end)
//
// One byte a cycle is taken while the bundle queue has room; tokens leave one
// a cycle from the output register while out_stall_i is low, so the slower side
// sets the sustained rate (up to four tokens per byte, the MaxTokens bundle limit).
// A token reaches the output through a queue entry and then the output register.
// Reset is asynchronous, active low, with no clearing pass. The input stalls
// only while the queue is full; the output stall holds the token register.
module markup_token_lexer_core #(
  parameter int unsigned QueueDepth = mtl_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mtl_pkg::mtl_in_t    in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output mtl_pkg::mtl_token_t out_data_o,
  input  logic                out_stall_i
);
  import mtl_pkg::*;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  mtl_bundle_t q_bundle;
  mtl_bundle_t q_head;

  mtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_bundle_o (q_bundle)
  );

  mtl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .bundle_i (q_bundle),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .empty_o  (q_empty),
    .head_o   (q_head)
  );

  mtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
